// File: hdl/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, command and event codes and the deadline ordering function
// used by the timer scheduler ring.
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] EVT_STARTED  = 2'd0;
  localparam logic [1:0] EVT_REJECTED = 2'd1;
  localparam logic [1:0] EVT_FIRED    = 2'd2;

  // what the head unit does with each slot passing by during one rotation
  typedef enum logic [1:0] {
    PM_STOP,
    PM_FIND,
    PM_WRITE
  } pass_mode_t;

  // one timer slot, id kept apart since its width is a parameter
  typedef struct packed {
    logic [31:0] deadline;
    logic [23:0] period;
    logic [15:0] order;
    logic        periodic;
    logic        cancelled;
  } entry_t;

  // per-cycle control from the sequencer to the head unit
  typedef struct packed {
    logic       shift;
    pass_mode_t mode;
    logic       first;
    logic       in_use;
    logic       last;
    logic       target;
  } head_ctrl_t;

  // wrapping deadline compare, enqueue order breaks ties
  function automatic logic earlier(entry_t a, entry_t b);
    logic [31:0] d;
    logic [15:0] o;
    d = a.deadline - b.deadline;
    o = a.order - b.order;
    if (d != 32'd0) return d[31];
    return o[15];
  endfunction

endpackage

// File: hdl/hts_cell.sv
// ----------------------------------------------------------------------------
// hts_cell
// One slot of the timer ring: holds an entry and hands it to its neighbor
// on every cycle that the ring rotates.
// ----------------------------------------------------------------------------
module hts_cell #(
  parameter int ID_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  hts_pkg::entry_t      d_ent,
  input  logic [ID_BITS-1:0]   d_ident,
  output hts_pkg::entry_t      q_ent,
  output logic [ID_BITS-1:0]   q_ident
);
  import hts_pkg::*;

  entry_t             ent_r;
  logic [ID_BITS-1:0] ident_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r   <= d_ent;
      ident_r <= d_ident;
    end
  end

  assign q_ent   = ent_r;
  assign q_ident = ident_r;

endmodule

// File: hdl/hts_head.sv
// ----------------------------------------------------------------------------
// hts_head
// Head of the timer ring. Sees one slot per cycle in slot order, finds the
// earliest entry, captures the last slot, cancels a matching id or writes
// a new entry into the target slot before it re-enters the ring.
// ----------------------------------------------------------------------------
module hts_head #(
  parameter int MAX_TIMERS = 64,
  parameter int ID_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hts_pkg::head_ctrl_t               ctrl,
  input  logic [$clog2(MAX_TIMERS)-1:0]     pos,
  input  logic [15:0]                       stop_id,
  input  hts_pkg::entry_t                   wr_ent,
  input  logic [ID_BITS-1:0]                wr_ident,
  input  hts_pkg::entry_t                   cur_ent,
  input  logic [ID_BITS-1:0]                cur_ident,
  output hts_pkg::entry_t                   ret_ent,
  output logic [ID_BITS-1:0]                ret_ident,
  output hts_pkg::entry_t                   best_ent,
  output logic [ID_BITS-1:0]                best_ident,
  output logic [$clog2(MAX_TIMERS)-1:0]     best_idx,
  output hts_pkg::entry_t                   last_ent,
  output logic [ID_BITS-1:0]                last_ident
);
  import hts_pkg::*;

  localparam int IdxW = $clog2(MAX_TIMERS);
  localparam int CmpW = (ID_BITS > 16) ? ID_BITS : 16;

  entry_t             best_ent_r;
  logic [ID_BITS-1:0] best_ident_r;
  logic [IdxW-1:0]    best_idx_r;
  entry_t             last_ent_r;
  logic [ID_BITS-1:0] last_ident_r;
  logic               matched_r;

  logic id_match;
  logic stop_hit;
  logic take_best;

  assign id_match = (CmpW'(cur_ident) == CmpW'(stop_id));

  // only the lowest live matching slot gets cancelled
  assign stop_hit = (ctrl.mode == PM_STOP) && ctrl.in_use && !cur_ent.cancelled &&
                    id_match && (ctrl.first || !matched_r);

  // slot zero seeds the search, later slots replace only when strictly earlier
  assign take_best = (ctrl.mode == PM_FIND) &&
                     (ctrl.first || (ctrl.in_use && earlier(cur_ent, best_ent_r)));

  always_comb begin
    ret_ent   = cur_ent;
    ret_ident = cur_ident;
    if (stop_hit) begin
      ret_ent.cancelled = 1'b1;
    end
    if ((ctrl.mode == PM_WRITE) && ctrl.target) begin
      ret_ent   = wr_ent;
      ret_ident = wr_ident;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_r <= 1'b0;
    end else if (ctrl.shift && (ctrl.mode == PM_STOP)) begin
      matched_r <= stop_hit | (!ctrl.first & matched_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift && take_best) begin
      best_ent_r   <= cur_ent;
      best_ident_r <= cur_ident;
      best_idx_r   <= pos;
    end
    if (ctrl.shift && (ctrl.mode == PM_FIND) && ctrl.last) begin
      last_ent_r   <= cur_ent;
      last_ident_r <= cur_ident;
    end
  end

  assign best_ent   = best_ent_r;
  assign best_ident = best_ident_r;
  assign best_idx   = best_idx_r;
  assign last_ent   = last_ent_r;
  assign last_ident = last_ident_r;

endmodule

// File: hdl/heap_timer_scheduler.sv
// ----------------------------------------------------------------------------
// heap_timer_scheduler
// Timer queue keyed by deadline with lazy cancel. Slots live in a ring of
// cells that rotates past one head unit, which searches and edits them.
//
//   channel  ports                                        direction
//   in       in_valid/in_ready, command interval periodic  consumer
//            timer_id
//   out      out_valid/out_ready, event_kind event_id      producer
//            event_time
//
// a start files the entry in one ring rotation, a full-queue start is
// rejected without one, a stop takes one rotation and a tick up to two (one
// rotation to find the earliest entry, one to update or remove it).
// rst_n is synchronous; no clearing pass, slot contents are valid by count.
// in_ready is high only between commands; a result waiting in the output
// register does not stop the next command until it has a result of its own.
// ----------------------------------------------------------------------------
module heap_timer_scheduler #(
  parameter int MAX_TIMERS = 64,
  parameter int ID_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [23:0] in_interval,
  input  logic        in_periodic,
  input  logic [15:0] in_timer_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [15:0] out_event_id,
  output logic [31:0] out_event_time
);
  import hts_pkg::*;

  localparam int IdxW = $clog2(MAX_TIMERS);
  localparam int CntW = $clog2(MAX_TIMERS + 1);
  localparam logic [IdxW-1:0] LastPos = IdxW'(MAX_TIMERS - 1);
  localparam logic [CntW-1:0] Full    = CntW'(MAX_TIMERS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS,
    S_RESOLVE,
    S_DONE
  } state_t;

  state_t             state_r;
  pass_mode_t         mode_r;
  logic [IdxW-1:0]    pos_r;
  logic [IdxW-1:0]    target_r;
  logic [CntW-1:0]    count_r;
  logic [31:0]        now_r;
  logic [15:0]        seq_r;
  logic [ID_BITS-1:0] next_id_r;
  logic [15:0]        stop_id_r;
  entry_t             wr_ent_r;
  logic [ID_BITS-1:0] wr_ident_r;
  logic               res_pend_r;
  logic [1:0]         res_kind_r;
  logic [15:0]        res_id_r;
  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [15:0]        out_id_r;
  logic [31:0]        out_time_r;

  head_ctrl_t         ctrl;
  entry_t             ring_ent   [MAX_TIMERS];
  logic [ID_BITS-1:0] ring_ident [MAX_TIMERS];
  entry_t             ret_ent;
  logic [ID_BITS-1:0] ret_ident;
  entry_t             best_ent;
  logic [ID_BITS-1:0] best_ident;
  logic [IdxW-1:0]    best_idx;
  entry_t             last_ent;
  logic [ID_BITS-1:0] last_ident;
  entry_t             refire_ent;
  logic [31:0]        due_diff;
  logic               due;

  assign ctrl.shift  = (state_r == S_PASS);
  assign ctrl.mode   = mode_r;
  assign ctrl.first  = (pos_r == '0);
  assign ctrl.in_use = (CntW'(pos_r) < count_r);
  assign ctrl.last   = ((CntW'(pos_r) + CntW'(1)) == count_r);
  assign ctrl.target = (pos_r == target_r);

  hts_head #(
    .MAX_TIMERS (MAX_TIMERS),
    .ID_BITS    (ID_BITS)
  ) u_head (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .pos        (pos_r),
    .stop_id    (stop_id_r),
    .wr_ent     (wr_ent_r),
    .wr_ident   (wr_ident_r),
    .cur_ent    (ring_ent[0]),
    .cur_ident  (ring_ident[0]),
    .ret_ent    (ret_ent),
    .ret_ident  (ret_ident),
    .best_ent   (best_ent),
    .best_ident (best_ident),
    .best_idx   (best_idx),
    .last_ent   (last_ent),
    .last_ident (last_ident)
  );

  // cell k holds slot pos+k; the head feeds the far end
  for (genvar k = 0; k < MAX_TIMERS; k++) begin : g_ring
    if (k == MAX_TIMERS - 1) begin : g_tail
      hts_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk     (clk),
        .en      (ctrl.shift),
        .d_ent   (ret_ent),
        .d_ident (ret_ident),
        .q_ent   (ring_ent[k]),
        .q_ident (ring_ident[k])
      );
    end else begin : g_mid
      hts_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk     (clk),
        .en      (ctrl.shift),
        .d_ent   (ring_ent[k+1]),
        .d_ident (ring_ident[k+1]),
        .q_ent   (ring_ent[k]),
        .q_ident (ring_ident[k])
      );
    end
  end

  // fires once now is strictly past the deadline, wrapping
  assign due_diff = now_r - best_ent.deadline;
  assign due      = !due_diff[31] && (due_diff != 32'd0);

  always_comb begin
    refire_ent          = best_ent;
    refire_ent.deadline = now_r + 32'(best_ent.period);
    refire_ent.order    = seq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= PM_STOP;
      pos_r       <= '0;
      count_r     <= '0;
      now_r       <= '0;
      seq_r       <= '0;
      next_id_r   <= '0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (in_command)
              CMD_START: begin
                res_pend_r <= 1'b1;
                if (count_r == Full) begin
                  res_kind_r <= EVT_REJECTED;
                  res_id_r   <= 16'd0;
                  state_r    <= S_DONE;
                end else begin
                  wr_ent_r.deadline  <= now_r + 32'(in_interval);
                  wr_ent_r.period    <= in_interval;
                  wr_ent_r.order     <= seq_r;
                  wr_ent_r.periodic  <= in_periodic;
                  wr_ent_r.cancelled <= 1'b0;
                  wr_ident_r         <= next_id_r;
                  target_r           <= IdxW'(count_r);
                  count_r            <= count_r + CntW'(1);
                  seq_r              <= seq_r + 16'd1;
                  next_id_r          <= next_id_r + ID_BITS'(1);
                  res_kind_r         <= EVT_STARTED;
                  res_id_r           <= 16'(next_id_r);
                  mode_r             <= PM_WRITE;
                  state_r            <= S_PASS;
                end
              end
              CMD_STOP: begin
                stop_id_r  <= in_timer_id;
                res_pend_r <= 1'b0;
                mode_r     <= PM_STOP;
                state_r    <= S_PASS;
              end
              CMD_TICK: begin
                now_r      <= now_r + 32'd1;
                res_pend_r <= 1'b0;
                if (count_r != '0) begin
                  mode_r  <= PM_FIND;
                  state_r <= S_PASS;
                end
              end
              default: ;
            endcase
          end
        end
        S_PASS: begin
          if (pos_r == LastPos) begin
            pos_r <= '0;
            if (mode_r == PM_FIND) begin
              state_r <= S_RESOLVE;
            end else if (res_pend_r) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            pos_r <= pos_r + IdxW'(1);
          end
        end
        S_RESOLVE: begin
          target_r <= best_idx;
          mode_r   <= PM_WRITE;
          if (best_ent.cancelled) begin
            // quiet removal, last slot moves into the freed one
            wr_ent_r   <= last_ent;
            wr_ident_r <= last_ident;
            count_r    <= count_r - CntW'(1);
            state_r    <= S_PASS;
          end else if (due) begin
            res_pend_r <= 1'b1;
            res_kind_r <= EVT_FIRED;
            res_id_r   <= 16'(best_ident);
            state_r    <= S_PASS;
            if (best_ent.periodic) begin
              wr_ent_r   <= refire_ent;
              wr_ident_r <= best_ident;
              seq_r      <= seq_r + 16'd1;
            end else begin
              wr_ent_r   <= last_ent;
              wr_ident_r <= last_ident;
              count_r    <= count_r - CntW'(1);
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_id_r    <= res_id_r;
            out_time_r  <= now_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_event_id   = out_id_r;
  assign out_event_time = out_time_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Full)
    else $error("entry count above capacity");

  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PASS) |-> (pos_r == '0))
    else $error("ring left unaligned outside a rotation");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == CMD_START) && (count_r == Full))
      |=> ((count_r == $past(count_r)) && (state_r == S_DONE)))
    else $error("rejected start changed the queue");

  a_find_resolves: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PASS) && (pos_r == LastPos) && (mode_r == PM_FIND))
      |=> (state_r == S_RESOLVE))
    else $error("search rotation did not resolve");

endmodule

// File: bench/hts_checker.sv
// ----------------------------------------------------------------------------
// hts_checker
// Watches both channels of the timer scheduler. It keeps its own copy of the
// timer queue, works out the event, if any, that each accepted command
// should cause, and compares every accepted result field by field against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module hts_checker #(
  parameter int MAX_TIMERS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [23:0] in_interval,
  input  logic        in_periodic,
  input  logic [15:0] in_timer_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_event_kind,
  input  logic [15:0] out_event_id,
  input  logic [31:0] out_event_time,
  output int          fail_count,
  output int          pending
);

  import hts_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [31:0] stamp;
  } timer_event_t;

  timer_event_t predicted_events[$];

  logic [31:0] tick_now;
  logic [15:0] id_next;
  logic [15:0] file_seq;
  int          live_count;
  entry_t      slots[MAX_TIMERS];
  logic [15:0] slot_id[MAX_TIMERS];
  int          errs = 0;

  // wrapping deadline order, filing order breaks ties
  function automatic logic precedes(int a, int b);
    logic [31:0] dd;
    logic [15:0] od;
    dd = slots[a].deadline - slots[b].deadline;
    od = slots[a].order - slots[b].order;
    if (dd != 32'd0) return dd[31];
    return od[15];
  endfunction

  // last slot moves into the freed one
  task automatic drop_slot(input int s);
    if (s != live_count - 1) begin
      slots[s]   = slots[live_count - 1];
      slot_id[s] = slot_id[live_count - 1];
    end
    live_count--;
  endtask

  task automatic add_event(input logic [1:0] kind, input logic [15:0] id);
    timer_event_t ev;
    ev.kind  = kind;
    ev.id    = id;
    ev.stamp = tick_now;
    predicted_events.push_back(ev);
  endtask

  task automatic schedule_command(input logic [1:0] cmd, input logic [23:0] ival,
                                  input logic per, input logic [15:0] tid);
    int          i;
    int          best;
    logic        found;
    logic [31:0] lag;
    case (cmd)
      CMD_START: begin
        if (live_count >= MAX_TIMERS) begin
          add_event(EVT_REJECTED, 16'd0);
        end else begin
          slots[live_count].deadline  = tick_now + 32'(ival);
          slots[live_count].period    = ival;
          slots[live_count].order     = file_seq;
          slots[live_count].periodic  = per;
          slots[live_count].cancelled = 1'b0;
          slot_id[live_count]         = id_next;
          live_count++;
          file_seq = file_seq + 16'd1;
          add_event(EVT_STARTED, id_next);
          id_next = id_next + 16'd1;
        end
      end
      CMD_STOP: begin
        found = 1'b0;
        for (i = 0; i < live_count; i++) begin
          if (!found && !slots[i].cancelled && slot_id[i] == tid) begin
            slots[i].cancelled = 1'b1;
            found = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        tick_now = tick_now + 32'd1;
        if (live_count != 0) begin
          best = 0;
          for (i = 1; i < live_count; i++) begin
            if (precedes(i, best)) best = i;
          end
          lag = tick_now - slots[best].deadline;
          if (slots[best].cancelled) begin
            drop_slot(best);
          end else if (!lag[31] && lag != 32'd0) begin
            add_event(EVT_FIRED, slot_id[best]);
            if (slots[best].periodic) begin
              slots[best].deadline = tick_now + 32'(slots[best].period);
              slots[best].order    = file_seq;
              file_seq = file_seq + 16'd1;
            end else begin
              drop_slot(best);
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    timer_event_t exp_ev;
    if (!rst_n) begin
      tick_now   = 32'd0;
      id_next    = 16'd0;
      file_seq   = 16'd0;
      live_count = 0;
      predicted_events.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_events.size() == 0) begin
          $error("unexpected result: event_kind %0d event_id %0d event_time %0d",
                 out_event_kind, out_event_id, out_event_time);
          errs++;
        end else begin
          exp_ev = predicted_events.pop_front();
          if (out_event_kind !== exp_ev.kind) begin
            $error("event_kind expected %0d actual %0d", exp_ev.kind, out_event_kind);
            errs++;
          end
          if (out_event_id !== exp_ev.id) begin
            $error("event_id expected %0d actual %0d", exp_ev.id, out_event_id);
            errs++;
          end
          if (out_event_time !== exp_ev.stamp) begin
            $error("event_time expected %0d actual %0d", exp_ev.stamp, out_event_time);
            errs++;
          end
        end
      end
      // a result never leaves in the cycle its command is accepted
      if (in_valid && in_ready)
        schedule_command(in_command, in_interval, in_periodic, in_timer_id);
    end
    fail_count <= errs;
    pending    <= predicted_events.size();
  end

endmodule

// File: bench/tb_heap_timer_scheduler.sv
// ----------------------------------------------------------------------------
// tb_heap_timer_scheduler
// Stimulus and verdict for the timer scheduler: a directed opening, random
// command traffic with queue fill and flush rounds, random stalls on both
// channels. Checking is done by hts_checker beside the block.
// ----------------------------------------------------------------------------
module tb_heap_timer_scheduler;

  import hts_pkg::*;

  localparam int MAX_TIMERS = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_TICK;
  logic [23:0] in_interval = 24'd0;
  logic        in_periodic = 1'b0;
  logic [15:0] in_timer_id = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_event_kind;
  logic [15:0] out_event_id;
  logic [31:0] out_event_time;

  int          fail_count;
  int          pending;
  logic        calm = 1'b0;
  int          stall_left = 0;
  logic [15:0] started_ids[$];

  heap_timer_scheduler #(
    .MAX_TIMERS(MAX_TIMERS),
    .ID_BITS   (16)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_interval   (in_interval),
    .in_periodic   (in_periodic),
    .in_timer_id   (in_timer_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_kind(out_event_kind),
    .out_event_id  (out_event_id),
    .out_event_time(out_event_time)
  );

  hts_checker #(
    .MAX_TIMERS(MAX_TIMERS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_interval   (in_interval),
    .in_periodic   (in_periodic),
    .in_timer_id   (in_timer_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_kind(out_event_kind),
    .out_event_id  (out_event_id),
    .out_event_time(out_event_time),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 17);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ids handed out by the block, used to aim stop commands
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_event_kind == EVT_STARTED)
      started_ids.push_back(out_event_id);
  end

  // called at a rising edge; returns at the edge where the transaction happens
  task automatic send_cmd(input logic [1:0] c, input logic [23:0] iv,
                          input logic p, input logic [15:0] tid);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= c;
    in_interval <= iv;
    in_periodic <= p;
    in_timer_id <= tid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] recent_id();
    int n;
    n = started_ids.size();
    if (n == 0) return 16'($urandom);
    return started_ids[n - 1 - $urandom_range(0, (n > 40) ? 39 : n - 1)];
  endfunction

  task automatic random_item();
    int          r;
    int          q;
    logic [23:0] iv;
    r  = $urandom_range(0, 99);
    q  = $urandom_range(0, 99);
    iv = 24'($urandom);
    if (r < 28) begin
      if (q < 70)      iv = 24'($urandom_range(0, 30));
      else if (q < 90) iv = 24'($urandom_range(31, 2000));
      else if (q < 95) iv = 24'hFF_FFFF;
      send_cmd(CMD_START, iv, $urandom_range(0, 3) == 0, 16'($urandom));
    end else if (r < 43) begin
      send_cmd(CMD_STOP, iv, 1'($urandom), (q < 80) ? recent_id() : 16'($urandom));
    end else if (r < 96) begin
      send_cmd(CMD_TICK, iv, 1'($urandom), 16'($urandom));
    end else begin
      send_cmd(2'd3, iv, 1'($urandom), 16'($urandom));
    end
  endtask

  // overfill the queue, cancel what was filed recently, then send ticks
  task automatic fill_and_flush();
    int i;
    int n;
    for (i = 0; i < MAX_TIMERS + 4; i++)
      send_cmd(CMD_START, 24'($urandom_range(2000, 60000)), 1'($urandom), 16'($urandom));
    wait_drained();
    n = started_ids.size();
    for (i = (n > 110) ? n - 110 : 0; i < n; i++)
      send_cmd(CMD_STOP, 24'($urandom), 1'($urandom), started_ids[i]);
    for (i = 0; i < 160; i++)
      send_cmd(CMD_TICK, 24'($urandom), 1'($urandom), 16'($urandom));
  endtask

  initial begin
    int i;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening
    send_cmd(CMD_TICK, 24'd0, 1'b0, 16'd0);              // empty queue
    send_cmd(CMD_START, 24'd0, 1'b0, 16'd0);             // due at once
    send_cmd(CMD_START, 24'hFF_FFFF, 1'b1, 16'hFFFF);    // far deadline
    send_cmd(CMD_START, 24'd2, 1'b1, 16'd0);
    send_cmd(CMD_START, 24'd5, 1'b0, 16'd0);
    send_cmd(CMD_STOP, 24'hFF_FFFF, 1'b1, 16'hFFFF);     // no match
    send_cmd(CMD_STOP, 24'd0, 1'b0, 16'd1);
    send_cmd(CMD_STOP, 24'd0, 1'b0, 16'd1);              // already cancelled
    for (i = 0; i < 3; i++)
      send_cmd(CMD_TICK, 24'd0, 1'b0, 16'd0);
    send_cmd(2'd3, 24'hFF_FFFF, 1'b1, 16'hFFFF);         // unknown command
    for (i = 0; i < 4; i++)
      send_cmd(CMD_TICK, 24'hFF_FFFF, 1'b1, 16'hFFFF);
    send_cmd(CMD_START, 24'd1, 1'b0, 16'd0);             // equal deadlines
    send_cmd(CMD_START, 24'd1, 1'b0, 16'd0);
    for (i = 0; i < 3; i++)
      send_cmd(CMD_TICK, 24'd0, 1'b0, 16'd0);
    send_cmd(CMD_STOP, 24'd0, 1'b0, 16'd2);              // cancel periodic
    for (i = 0; i < 3; i++)
      send_cmd(CMD_TICK, 24'd0, 1'b0, 16'd0);

    for (i = 0; i < 500; i++) random_item();
    fill_and_flush();
    for (i = 0; i < 300; i++) random_item();
    fill_and_flush();
    calm = 1'b1;
    for (i = 0; i < 150; i++) random_item();

    wait_drained();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      if (pending != 0) $error("%0d expected results never arrived", pending);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/hts_pkg.sv
hdl/hts_cell.sv
hdl/hts_head.sv
hdl/heap_timer_scheduler.sv
bench/hts_checker.sv
bench/tb_heap_timer_scheduler.sv
